>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the columnar transposition block.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CTC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CTC_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/ctc_pkg.sv
// Shared types and constants of the columnar transposition block.
// No dependencies; imported by every module of the block.
package ctc_pkg;

  localparam int MAX_LEN_DEF  = 64;
  localparam int MAX_COLS_DEF = 8;

  localparam int KEY_SLOTS = 8;
  localparam int COL_W     = 3;
  localparam int CNT_W     = 4;
  localparam int KEY_W     = 24;
  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 13;
  localparam int IDX_W     = 12;
  localparam int CFG_W     = 24;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_ORDER    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DECRYPT_MODE = 2'd2;

  localparam logic [CNT_W-1:0] COLUMN_COUNT_RST = 4'd8;
  localparam logic [KEY_W-1:0] KEY_ORDER_RST    = 24'd16434824;

  typedef struct packed {
    logic [CHAR_W-1:0] char_in;
    logic              last_in;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last_out;
    logic              truncated;
  } out_t;

  // Buffer write from the front end.
  typedef struct packed {
    logic              en;
    logic              half;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] data;
  } wr_t;

  // One complete message waiting for the back end.
  typedef struct packed {
    logic [LEN_W-1:0]                  len;
    logic                              ovf;
    logic                              half;
    logic [CNT_W-1:0]                  cols;
    logic [KEY_SLOTS-1:0][COL_W-1:0]   order;
    logic                              dec;
  } desc_t;

endpackage

>>> hdl/columnar_transposition_cipher.sv
// Top level of the columnar transposition block: front end, descriptor
// queue and back end. Depends on ctc_pkg, ctc_front, ctc_desc_q, ctc_back.
//
// Usage:
//   Input queue: drive item and raise push; a transaction completes at a
//   clock edge with push high and full low. One byte may enter every cycle.
//   The byte with last_in set closes the message. Bytes past MAX_LEN are
//   dropped and every result of that message carries truncated.
//   Result queue: while empty is low, result holds the oldest byte; a
//   transaction completes at an edge with pop high and empty low.
//   Configuration: cfg_we writes register cfg_index (0 column_count,
//   1 key_order, 2 decrypt_mode) at once; write only while the block is idle.
//   Values are taken when the last byte of a message is accepted.
// Timing:
//   The buffer holds two messages; one is read out while the next is filled,
//   and full rises only while both halves are occupied.
//   After the last byte a bit-serial row count runs first, then the column
//   starts are placed; the first result follows.
//   Read-out is one byte per cycle while the result queue has room, set by
//   the single buffer read port; in encrypt mode reads pause between columns.
// Reset: rst (synchronous) empties both queues, drops any partial message
//   and restores the default key. When pop stays low, the four-entry result
//   queue fills, reads hold, and the buffer half stays locked until drained.
module columnar_transposition_cipher import ctc_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_t                  item,
  output logic                 empty,
  input  logic                 pop,
  output out_t                 result,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  wr_t   wr;
  desc_t desc_in;
  desc_t desc_head;
  logic  desc_push;
  logic  desc_full;
  logic  desc_empty;
  logic  desc_pop;

  // Intake: store bytes, snapshot the key at the last byte.
  ctc_front #(
    .MAX_LEN  (MAX_LEN),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .desc      (desc_in),
    .desc_push (desc_push),
    .desc_full (desc_full)
  );

  // Hold finished messages until the back end has read them out.
  ctc_desc_q u_desc_q (
    .clk     (clk),
    .rst     (rst),
    .push_d  (desc_push),
    .din     (desc_in),
    .q_full  (desc_full),
    .pop_d   (desc_pop),
    .head    (desc_head),
    .q_empty (desc_empty)
  );

  // Read-out in permuted order.
  ctc_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .desc       (desc_head),
    .desc_empty (desc_empty),
    .desc_pop   (desc_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

>>> hdl/ctc_front.sv
// Front end: configuration registers, byte intake into the double buffer,
// key check and message descriptors. Depends on ctc_pkg.
module ctc_front import ctc_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_t                  item,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output wr_t                  wr,
  output desc_t                desc,
  output logic                 desc_push,
  input  logic                 desc_full
);

  localparam int FILL_W  = $clog2(MAX_LEN + 1);
  localparam int COL_LIM = (MAX_COLS < KEY_SLOTS) ? MAX_COLS : KEY_SLOTS;
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(MAX_LEN);
  localparam logic [CNT_W-1:0]  COL_LIM_C = CNT_W'(COL_LIM);

  logic [CNT_W-1:0]  column_count;
  logic [KEY_W-1:0]  key_order;
  logic              decrypt_mode;
  logic [FILL_W-1:0] fill;
  logic              ovf;
  logic              half;

  logic                            accept;
  logic                            has_room;
  logic [CNT_W-1:0]                cols_eff;
  logic [KEY_SLOTS-1:0][COL_W-1:0] order_v;

  assign full     = desc_full;
  assign accept   = push & ~desc_full;
  assign has_room = fill < FILL_MAX;

  always_comb begin
    if (column_count == '0) begin
      cols_eff = CNT_W'(1);
    end else if (column_count > COL_LIM_C) begin
      cols_eff = COL_LIM_C;
    end else begin
      cols_eff = column_count;
    end
  end

  // Fall back to the identity order unless the key is a permutation.
  always_comb begin
    logic [KEY_SLOTS-1:0] seen;
    logic                 ok;
    logic [COL_W-1:0]     e;
    seen = '0;
    ok   = 1'b1;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      e = key_order[COL_W*j +: COL_W];
      if (CNT_W'(j) < cols_eff) begin
        if ({1'b0, e} >= cols_eff || seen[e]) begin
          ok = 1'b0;
        end
        seen[e] = 1'b1;
      end
    end
    for (int j = 0; j < KEY_SLOTS; j++) begin
      order_v[j] = ok ? key_order[COL_W*j +: COL_W] : COL_W'(j);
    end
  end

  assign wr.en   = accept & has_room;
  assign wr.half = half;
  assign wr.idx  = IDX_W'(fill);
  assign wr.data = item.char_in;

  assign desc_push  = accept & item.last_in;
  assign desc.len   = LEN_W'(fill) + LEN_W'(has_room);
  assign desc.ovf   = ovf | ~has_room;
  assign desc.half  = half;
  assign desc.cols  = cols_eff;
  assign desc.order = order_v;
  assign desc.dec   = decrypt_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= COLUMN_COUNT_RST;
      key_order    <= KEY_ORDER_RST;
      decrypt_mode <= 1'b0;
      fill         <= '0;
      ovf          <= 1'b0;
      half         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLUMN_COUNT: column_count <= cfg_data[CNT_W-1:0];
          REG_KEY_ORDER:    key_order    <= cfg_data[KEY_W-1:0];
          REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
          default:          ;
        endcase
      end
      if (accept) begin
        if (item.last_in) begin
          fill <= '0;
          ovf  <= 1'b0;
          half <= ~half;
        end else if (has_room) begin
          fill <= fill + FILL_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/ctc_desc_q.sv
// Two-entry descriptor queue between front and back end; one entry per
// buffer half. Depends on ctc_pkg.
module ctc_desc_q import ctc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_d,
  input  desc_t din,
  output logic  q_full,
  input  logic  pop_d,
  output desc_t head,
  output logic  q_empty
);

  desc_t      ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign q_full  = cnt == 2'd2;
  assign q_empty = cnt == 2'd0;
  assign head    = ent[rp];

  always_ff @(posedge clk) begin
    if (push_d) begin
      ent[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push_d) begin
        wp <= ~wp;
      end
      if (pop_d) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push_d) - 2'(pop_d);
    end
  end

endmodule

>>> hdl/ctc_back.sv
// Back end: message buffer, row/column split, read sequencer and result
// queue. Depends on ctc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctc_back import ctc_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  wr_t   wr,
  input  desc_t desc,
  input  logic  desc_empty,
  output logic  desc_pop,
  output logic  empty,
  input  logic  pop,
  output out_t  result
);

  localparam int FILL_W   = $clog2(MAX_LEN + 1);
  localparam int AW       = $clog2(2 * MAX_LEN);
  localparam int DIV_CW   = $clog2(FILL_W);
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;
  localparam logic [OQ_CW-1:0] OQ_FULL = OQ_CW'(OQ_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_SETUP = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  logic [CHAR_W-1:0] mem [2*MAX_LEN];

  logic [1:0]        state;
  logic [FILL_W-1:0] dvd;
  logic [FILL_W-1:0] quo;
  logic [COL_W-1:0]  rem;
  logic [DIV_CW-1:0] dcnt;
  logic [COL_W-1:0]  jj;
  logic [FILL_W-1:0] acc;
  logic [FILL_W-1:0] start [KEY_SLOTS];
  logic [FILL_W-1:0] k;
  logic [FILL_W-1:0] x;
  logic [FILL_W-1:0] p;
  logic [COL_W-1:0]  cd;
  logic [FILL_W-1:0] r;

  logic              rd_v;
  logic [CHAR_W-1:0] rd_data;
  logic              rd_last;
  logic              rd_trunc;

  out_t              oq [OQ_DEPTH];
  logic [OQ_AW-1:0]  owp;
  logic [OQ_AW-1:0]  orp;
  logic [OQ_CW-1:0]  ocnt;

  logic [FILL_W-1:0] len;
  logic [CNT_W-1:0]  c_m1;
  logic [CNT_W-1:0]  rs;
  logic [CNT_W-1:0]  rs_sub;
  logic              ge;
  logic [COL_W-1:0]  rem_next;
  logic [COL_W-1:0]  cur_col;
  logic [FILL_W-1:0] cur_n;
  logic              enc_go;
  logic              credit;
  logic              issue;
  logic              issue_last;
  logic              adv;
  logic [FILL_W-1:0] rel;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic              oq_rd;

  assign len  = desc.len[FILL_W-1:0];
  assign c_m1 = desc.cols - CNT_W'(1);

  // One quotient bit per cycle; the divisor is at most eight.
  assign rs       = {rem, dvd[FILL_W-1]};
  assign ge       = rs >= desc.cols;
  assign rs_sub   = rs - desc.cols;
  assign rem_next = ge ? rs_sub[COL_W-1:0] : rs[COL_W-1:0];

  // Length of the column taken jj-th in key order.
  assign cur_col = desc.order[jj];
  assign cur_n   = quo + ((cur_col < rem) ? FILL_W'(1) : FILL_W'(0));

  assign credit     = (ocnt + OQ_CW'(rd_v)) < OQ_FULL;
  assign enc_go     = x < cur_n;
  assign issue      = (state == ST_RUN) && credit && (desc.dec || enc_go);
  assign adv        = (state == ST_RUN) && credit && !desc.dec && !enc_go;
  assign issue_last = issue && ((k + FILL_W'(1)) == len);
  assign desc_pop   = issue_last;

  assign rel   = desc.dec ? (start[cd] + r) : p;
  assign raddr = desc.half ? (AW'(rel) + AW'(MAX_LEN)) : AW'(rel);
  assign waddr = wr.half ? (AW'(wr.idx) + AW'(MAX_LEN)) : AW'(wr.idx);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data  <= mem[raddr];
      rd_last  <= issue_last;
      rd_trunc <= desc.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= issue;
      unique case (state)
        ST_IDLE:  if (!desc_empty) state <= ST_DIV;
        ST_DIV:   if (dcnt == '0) state <= ST_SETUP;
        ST_SETUP: if ({1'b0, jj} == c_m1) state <= ST_RUN;
        ST_RUN:   if (issue_last) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer datapath; every counter is loaded on entry to its state.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        dvd  <= len;
        quo  <= '0;
        rem  <= '0;
        dcnt <= DIV_CW'(FILL_W - 1);
      end
      ST_DIV: begin
        dvd <= dvd << 1;
        quo <= {quo[FILL_W-2:0], ge};
        rem <= rem_next;
        dcnt <= dcnt - DIV_CW'(1);
        jj  <= '0;
        acc <= '0;
      end
      ST_SETUP: begin
        start[cur_col] <= acc;
        acc <= acc + cur_n;
        if ({1'b0, jj} == c_m1) begin
          jj <= '0;
          k  <= '0;
          x  <= '0;
          p  <= FILL_W'(desc.order[0]);
          cd <= '0;
          r  <= '0;
        end else begin
          jj <= jj + COL_W'(1);
        end
      end
      ST_RUN: begin
        if (issue) begin
          k <= k + FILL_W'(1);
          if (desc.dec) begin
            if ({1'b0, cd} == c_m1) begin
              cd <= '0;
              r  <= r + FILL_W'(1);
            end else begin
              cd <= cd + COL_W'(1);
            end
          end else begin
            x <= x + FILL_W'(1);
            p <= p + FILL_W'(desc.cols);
          end
        end else if (adv) begin
          jj <= jj + COL_W'(1);
          x  <= '0;
          p  <= FILL_W'(desc.order[jj + COL_W'(1)]);
        end
      end
      default: ;
    endcase
  end

  // Result queue.
  assign empty  = ocnt == '0;
  assign oq_rd  = pop && !empty;
  assign result = oq[orp];

  always_ff @(posedge clk) begin
    if (rd_v) begin
      oq[owp] <= '{char_out: rd_data, last_out: rd_last, truncated: rd_trunc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= '0;
      orp  <= '0;
      ocnt <= '0;
    end else begin
      if (rd_v) begin
        owp <= owp + OQ_AW'(1);
      end
      if (oq_rd) begin
        orp <= orp + OQ_AW'(1);
      end
      ocnt <= ocnt + OQ_CW'(rd_v) - OQ_CW'(oq_rd);
    end
  end

  `CTC_ASSERT(a_oq_bound, clk, rst, (ocnt + OQ_CW'(rd_v)) <= OQ_FULL, "result queue overrun")
  `CTC_ASSERT_NEVER(a_busy_no_desc, clk, rst, (state != ST_IDLE) && desc_empty, "back end busy without a message")
  `CTC_ASSERT(a_run_in_msg, clk, rst, (state == ST_RUN) |-> (k < len), "result count past message length")
  `CTC_ASSERT(a_enc_addr, clk, rst, (issue && !desc.dec) |-> (p < len), "encrypt read outside message")

endmodule
